/* hdl/taqe_pkg.sv */
// ----------------------------------------------------------------------------
// taqe_pkg
// shared widths and codes of the tree ancestor query engine
// ----------------------------------------------------------------------------
package taqe_pkg;

    localparam int VTX_W     = 10;
    localparam int DEP_W     = 10;
    localparam int STEP_W    = 10;
    localparam int DIST_W    = 11;
    localparam int TOTAL_W   = 11;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BIT_W     = $clog2(STEP_W + 1);
    localparam int REP_W     = STEP_W - 1;

    typedef logic [VTX_W-1:0]  t_vertex;
    typedef logic [DEP_W-1:0]  t_depth;
    typedef logic [STEP_W-1:0] t_steps;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_LCA   = 2'd2;
    localparam logic [OP_W-1:0] OP_KTH   = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_VERTEX  = 2'd1;

endpackage

/* hdl/taqe_ram.sv */
// ----------------------------------------------------------------------------
// taqe_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module taqe_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tree_ancestor_query_engine.sv */
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine
// binary lifting ancestor engine: load, build levels, lca and kth ancestor
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       to block   i_in_valid / o_in_ready     op, vertex_a, vertex_b, depth_in, steps
//  out      from block o_out_valid / i_out_ready   ancestor, distance, status
//  cfg      to block   i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
//  one item at a time, all tables read through one registered ram port each
//  load or range error: answered straight from idle; build: one read pair and one write per entry
//  lca: read both depths, climb, then scan the levels top-down unless the lift meets; kth: depth check, climb
//  climb: step bits from low to high, one ancestor table read per set bit (repeated above the top level)
//  synchronous reset sets control and config only (one vertex, root 0); tables are undefined until loaded
//  a result waits in the output register while the next transfer is taken
// ----------------------------------------------------------------------------
module tree_ancestor_query_engine
    import taqe_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int LIFT_LEVELS  = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_op,
    input  logic [VTX_W-1:0]     i_vertex_a,
    input  logic [VTX_W-1:0]     i_vertex_b,
    input  logic [DEP_W-1:0]     i_depth_in,
    input  logic [STEP_W-1:0]    i_steps,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [VTX_W-1:0]     o_ancestor,
    output logic [DIST_W-1:0]    o_distance,
    output logic [STAT_W-1:0]    o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOTAL_W-1:0]   i_cfg_data
);

    localparam int AW       = $clog2(MAX_VERTICES);
    localparam int LW       = $clog2(LIFT_LEVELS);
    localparam int AAW      = AW + LW;
    localparam int AN_DEPTH = LIFT_LEVELS * (2 ** AW);
    localparam logic [LW-1:0] TOP_LVL = LW'(LIFT_LEVELS - 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DEP_A    = 5'd1;
    localparam logic [4:0] S_DEP_B    = 5'd2;
    localparam logic [4:0] S_KTH_DEP  = 5'd3;
    localparam logic [4:0] S_CLB_BIT  = 5'd4;
    localparam logic [4:0] S_CLB_RD   = 5'd5;
    localparam logic [4:0] S_CLB_ISS  = 5'd6;
    localparam logic [4:0] S_LCA_CHK  = 5'd7;
    localparam logic [4:0] S_LCA_ISX  = 5'd8;
    localparam logic [4:0] S_LCA_RDX  = 5'd9;
    localparam logic [4:0] S_LCA_RDY  = 5'd10;
    localparam logic [4:0] S_LCA_TOP  = 5'd11;
    localparam logic [4:0] S_LCA_PAR  = 5'd12;
    localparam logic [4:0] S_LCA_DIST = 5'd13;
    localparam logic [4:0] S_BLD_R1   = 5'd14;
    localparam logic [4:0] S_BLD_R2   = 5'd15;
    localparam logic [4:0] S_BLD_WR   = 5'd16;
    localparam logic [4:0] S_DONE     = 5'd17;

    logic [4:0]         r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    t_vertex            r_a, n_a;
    t_vertex            r_b, n_b;
    t_vertex            r_x, n_x;
    t_vertex            r_y, n_y;
    t_vertex            r_ux, n_ux;
    t_depth             r_da, n_da;
    t_depth             r_db, n_db;
    t_steps             r_k, n_k;
    logic [BIT_W-1:0]   r_j, n_j;
    logic [REP_W-1:0]   r_reps, n_reps;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic [TOTAL_W-1:0] r_v, n_v;
    t_vertex            r_res_anc, n_res_anc;
    logic [DIST_W-1:0]  r_res_dist, n_res_dist;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    t_vertex            r_out_anc, n_out_anc;
    logic [DIST_W-1:0]  r_out_dist, n_out_dist;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [TOTAL_W-1:0] r_vertex_total;
    t_vertex            r_root;

    logic               anc_we;
    logic [AAW-1:0]     anc_waddr, anc_raddr;
    t_vertex            anc_wdata, anc_rdata;
    logic               dep_we;
    logic [AW-1:0]      dep_waddr, dep_raddr;
    t_depth             dep_wdata, dep_rdata;

    logic [TOTAL_W-1:0] w_live;
    logic               w_a_ok, w_b_ok;
    logic [LW-1:0]      w_climb_lvl;
    logic [REP_W-1:0]   w_reps;
    logic [BIT_W-1:0]   w_rep_shift;
    logic               w_in_xfer;

    taqe_ram #(.WIDTH(VTX_W), .DEPTH(AN_DEPTH)) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    taqe_ram #(.WIDTH(DEP_W), .DEPTH(MAX_VERTICES)) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    assign w_live = ({6'd0, r_vertex_total} < 17'(MAX_VERTICES)) ?
                    r_vertex_total : TOTAL_W'(MAX_VERTICES);
    assign w_a_ok = ({1'b0, i_vertex_a} < w_live);
    assign w_b_ok = ({1'b0, i_vertex_b} < w_live);

    assign w_rep_shift = BIT_W'(int'(r_j) - (LIFT_LEVELS - 1));
    assign w_climb_lvl = (int'(r_j) < LIFT_LEVELS) ? LW'(r_j) : TOP_LVL;
    assign w_reps      = (int'(r_j) < LIFT_LEVELS) ? REP_W'(1) :
                         (REP_W'(1) << w_rep_shift);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_a          = r_a;
        n_b          = r_b;
        n_x          = r_x;
        n_y          = r_y;
        n_ux         = r_ux;
        n_da         = r_da;
        n_db         = r_db;
        n_k          = r_k;
        n_j          = r_j;
        n_reps       = r_reps;
        n_lvl        = r_lvl;
        n_v          = r_v;
        n_res_anc    = r_res_anc;
        n_res_dist   = r_res_dist;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_anc    = r_out_anc;
        n_out_dist   = r_out_dist;
        n_out_status = r_out_status;
        anc_we       = 1'b0;
        anc_waddr    = {LW'(0), AW'(i_vertex_a)};
        anc_wdata    = i_vertex_b;
        anc_raddr    = {w_climb_lvl, AW'(r_x)};
        dep_we       = 1'b0;
        dep_waddr    = AW'(i_vertex_a);
        dep_wdata    = i_depth_in;
        dep_raddr    = AW'(i_vertex_a);

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op         = i_op;
                    n_a          = i_vertex_a;
                    n_b          = i_vertex_b;
                    n_k          = i_steps;
                    n_res_anc    = '0;
                    n_res_dist   = '0;
                    n_res_status = STATUS_OK;
                    n_state      = S_DONE;
                    case (i_op)
                        OP_LOAD: begin
                            if (!w_a_ok || !w_b_ok) begin
                                n_res_status = STATUS_RANGE;
                            end else begin
                                anc_we = 1'b1;
                                dep_we = 1'b1;
                                if (i_vertex_a == r_root) begin
                                    anc_wdata = i_vertex_a;
                                    dep_wdata = '0;
                                end
                            end
                        end
                        OP_BUILD: begin
                            n_lvl = LW'(1);
                            n_v   = '0;
                            if (w_live != '0) begin
                                n_state = S_BLD_R1;
                            end
                        end
                        OP_LCA: begin
                            if (!w_a_ok || !w_b_ok) begin
                                n_res_status = STATUS_RANGE;
                            end else begin
                                n_state = S_DEP_A;
                            end
                        end
                        OP_KTH: begin
                            if (!w_a_ok) begin
                                n_res_status = STATUS_RANGE;
                            end else begin
                                n_state = S_KTH_DEP;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DEP_A: begin
                n_da      = dep_rdata;
                dep_raddr = AW'(r_b);
                n_state   = S_DEP_B;
            end
            S_DEP_B: begin
                n_db = dep_rdata;
                n_j  = '0;
                if (r_da < dep_rdata) begin
                    n_x = r_b;
                    n_y = r_a;
                    n_k = dep_rdata - r_da;
                end else begin
                    n_x = r_a;
                    n_y = r_b;
                    n_k = r_da - dep_rdata;
                end
                n_state = S_CLB_BIT;
            end
            S_KTH_DEP: begin
                if (r_k > dep_rdata) begin
                    n_res_status = STATUS_NONE;
                    n_state      = S_DONE;
                end else begin
                    n_x     = r_a;
                    n_j     = '0;
                    n_state = S_CLB_BIT;
                end
            end
            S_CLB_BIT: begin
                if (int'(r_j) == STEP_W) begin
                    if (r_op == OP_KTH) begin
                        n_res_anc = r_x;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_LCA_CHK;
                    end
                end else if (!r_k[r_j]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_reps  = w_reps;
                    n_state = S_CLB_RD;
                end
            end
            S_CLB_RD: begin
                n_x = anc_rdata;
                if (r_reps == REP_W'(1)) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_CLB_BIT;
                end else begin
                    n_reps  = r_reps - 1'b1;
                    n_state = S_CLB_ISS;
                end
            end
            S_CLB_ISS: begin
                n_state = S_CLB_RD;
            end
            S_LCA_CHK: begin
                dep_raddr = AW'(r_x);
                if (r_x == r_y) begin
                    n_state = S_LCA_DIST;
                end else begin
                    n_lvl   = TOP_LVL;
                    n_state = S_LCA_ISX;
                end
            end
            S_LCA_ISX: begin
                anc_raddr = {r_lvl, AW'(r_x)};
                n_state   = S_LCA_RDX;
            end
            S_LCA_RDX: begin
                n_ux      = anc_rdata;
                anc_raddr = {r_lvl, AW'(r_y)};
                n_state   = S_LCA_RDY;
            end
            S_LCA_RDY: begin
                if (r_ux != anc_rdata) begin
                    n_x = r_ux;
                    n_y = anc_rdata;
                end
                if (r_lvl == '0) begin
                    n_state = S_LCA_TOP;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_LCA_ISX;
                end
            end
            S_LCA_TOP: begin
                anc_raddr = {LW'(0), AW'(r_x)};
                n_state   = S_LCA_PAR;
            end
            S_LCA_PAR: begin
                n_x       = anc_rdata;
                dep_raddr = AW'(anc_rdata);
                n_state   = S_LCA_DIST;
            end
            S_LCA_DIST: begin
                n_res_anc  = r_x;
                n_res_dist = DIST_W'({1'b0, r_da}) + DIST_W'({1'b0, r_db})
                             - {dep_rdata, 1'b0};
                n_state    = S_DONE;
            end
            S_BLD_R1: begin
                anc_raddr = {LW'(r_lvl - 1'b1), AW'(r_v)};
                n_state   = S_BLD_R2;
            end
            S_BLD_R2: begin
                anc_raddr = {LW'(r_lvl - 1'b1), AW'(anc_rdata)};
                n_state   = S_BLD_WR;
            end
            S_BLD_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {r_lvl, AW'(r_v)};
                anc_wdata = anc_rdata;
                if (TOTAL_W'(r_v + 1'b1) == w_live) begin
                    n_v = '0;
                    if (r_lvl == TOP_LVL) begin
                        n_state = S_DONE;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = S_BLD_R1;
                    end
                end else begin
                    n_v     = r_v + 1'b1;
                    n_state = S_BLD_R1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_anc    = r_res_anc;
                    n_out_dist   = r_res_dist;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_vertex_total <= TOTAL_W'(1);
            r_root         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VERTEX_TOTAL: r_vertex_total <= i_cfg_data;
                    CFG_ROOT_VERTEX:  r_root <= i_cfg_data[VTX_W-1:0];
                    default: begin
                        r_root <= r_root;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_x          <= n_x;
        r_y          <= n_y;
        r_ux         <= n_ux;
        r_da         <= n_da;
        r_db         <= n_db;
        r_k          <= n_k;
        r_j          <= n_j;
        r_reps       <= n_reps;
        r_lvl        <= n_lvl;
        r_v          <= n_v;
        r_res_anc    <= n_res_anc;
        r_res_dist   <= n_res_dist;
        r_res_status <= n_res_status;
        r_out_anc    <= n_out_anc;
        r_out_dist   <= n_out_dist;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_out_anc;
    assign o_distance  = r_out_dist;
    assign o_status    = r_out_status;

    // a taken transfer always drops the input ready in the following cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("input taken again without a finished item");

    // error results carry no ancestor and no distance
    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_OK) |-> (o_ancestor == '0 && o_distance == '0))
        else $error("error result with non-zero payload");

    // build never overwrites the parent level
    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLD_WR) |-> (r_lvl != '0 && anc_we))
        else $error("build write at parent level");

    // a climb read always has a repeat pending
    a_climb_reps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLB_RD) |-> (r_reps != '0))
        else $error("climb read with empty repeat count");

    // a finished result reaches the output register and frees the input
    a_done_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> (o_out_valid && o_in_ready))
        else $error("finished result not handed to the output");

endmodule

/* tb/taqe_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taqe_tb_pkg
// expected-answer bookkeeping for the tree ancestor query engine bench:
// a private copy of the lifting tables and registers is advanced on every
// accepted transfer, and each answer is compared field by field in order
// ----------------------------------------------------------------------------
package taqe_tb_pkg;

    import taqe_pkg::*;

    localparam int LEVELS   = 11;
    localparam int VERTICES = 1024;

    typedef struct packed {
        t_vertex             ancestor;
        logic [DIST_W-1:0]   distance;
        logic [STAT_W-1:0]   status;
    } t_answer;

    class t_lca_scoreboard;
        t_vertex            up_tbl [LEVELS][VERTICES];
        t_depth             depth_tbl [VERTICES];
        logic [TOTAL_W-1:0] vertex_total;
        t_vertex            root;
        t_answer            awaited [$];
        int unsigned        faults;

        function new();
            foreach (up_tbl[l, v]) up_tbl[l][v] = '0;
            foreach (depth_tbl[v]) depth_tbl[v] = '0;
            vertex_total = TOTAL_W'(1);
            root         = '0;
            faults       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] data);
            if (idx == CFG_VERTEX_TOTAL) begin
                vertex_total = data;
            end else if (idx == CFG_ROOT_VERTEX) begin
                root = data[VTX_W-1:0];
            end
        endfunction

        // links and levels past the table read as vertex zero
        function int unsigned hop(int unsigned lvl, int unsigned v);
            if (lvl >= LEVELS || v >= VERTICES) return 0;
            return 32'(up_tbl[lvl][v]);
        endfunction

        // climb by the binary digits of the count
        function int unsigned lift(int unsigned v, int unsigned cnt);
            for (int lvl = 0; lvl < STEP_W; lvl++) begin
                if (((cnt >> lvl) & 1) != 0) v = hop(lvl, v);
            end
            return v;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_item(logic [OP_W-1:0] op, t_vertex a, t_vertex b,
                                t_depth dep, t_steps k);
            int unsigned n;
            int unsigned x;
            int unsigned y;
            int unsigned dx;
            int unsigned dy;
            int unsigned t;
            int unsigned span;
            t_answer     ans;
            n   = (vertex_total < VERTICES) ? 32'(vertex_total) : VERTICES;
            ans = '0;
            case (op)
                OP_LOAD: begin
                    if (32'(a) >= n || 32'(b) >= n) begin
                        ans.status = STATUS_RANGE;
                    end else if (a == root) begin
                        up_tbl[0][a] = a;
                        depth_tbl[a] = '0;
                    end else begin
                        up_tbl[0][a] = b;
                        depth_tbl[a] = dep;
                    end
                end
                OP_BUILD: begin
                    for (int l = 1; l < LEVELS; l++) begin
                        for (int unsigned v = 0; v < n; v++) begin
                            up_tbl[l][v] = VTX_W'(hop(l - 1, hop(l - 1, v)));
                        end
                    end
                end
                OP_LCA: begin
                    if (32'(a) >= n || 32'(b) >= n) begin
                        ans.status = STATUS_RANGE;
                    end else begin
                        x  = 32'(a);
                        y  = 32'(b);
                        dx = 32'(depth_tbl[a]);
                        dy = 32'(depth_tbl[b]);
                        if (dx < dy) begin
                            t = x; x = y; y = t;
                            t = dx; dx = dy; dy = t;
                        end
                        x = lift(x, dx - dy);
                        if (x != y) begin
                            for (int l = LEVELS - 1; l >= 0; l--) begin
                                if (hop(l, x) != hop(l, y)) begin
                                    t = hop(l, x);
                                    y = hop(l, y);
                                    x = t;
                                end
                            end
                            x = hop(0, x);
                        end
                        // wraps when the loaded depths disagree with the parents
                        span = 32'(depth_tbl[a]) + 32'(depth_tbl[b])
                               - 2 * 32'(depth_tbl[x]);
                        ans.ancestor = VTX_W'(x);
                        ans.distance = DIST_W'(span);
                    end
                end
                default: begin
                    if (32'(a) >= n) begin
                        ans.status = STATUS_RANGE;
                    end else if (k > depth_tbl[a]) begin
                        ans.status = STATUS_NONE;
                    end else begin
                        ans.ancestor = VTX_W'(lift(32'(a), 32'(k)));
                    end
                end
            endcase
            awaited = {awaited, ans};
        endfunction

        function void check_result(t_vertex anc, logic [DIST_W-1:0] got_dist,
                                   logic [STAT_W-1:0] st);
            t_answer want;
            if (awaited.size() == 0) begin
                $error("answer with nothing outstanding: ancestor %0d distance %0d status %0d",
                       anc, got_dist, st);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (anc !== want.ancestor) begin
                $error("ancestor mismatch: expected %0d, actual %0d", want.ancestor, anc);
                faults++;
            end
            if (got_dist !== want.distance) begin
                $error("distance mismatch: expected %0d, actual %0d", want.distance, got_dist);
                faults++;
            end
            if (st !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, st);
                faults++;
            end
        endfunction
    endclass

endpackage

/* tb/tree_ancestor_query_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_test
// loads random rooted trees of many sizes and shapes, builds the lifting
// levels and fires common ancestor and kth ancestor queries at them, with
// random gaps on the request side and random back-pressure on the answers
// ----------------------------------------------------------------------------
module tree_ancestor_query_engine_test;

    import taqe_pkg::*;
    import taqe_tb_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_op        = OP_LOAD;
    t_vertex              i_vertex_a  = '0;
    t_vertex              i_vertex_b  = '0;
    t_depth               i_depth_in  = '0;
    t_steps               i_steps     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_vertex              o_ancestor;
    logic [DIST_W-1:0]    o_distance;
    logic [STAT_W-1:0]    o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_VERTEX_TOTAL;
    logic [TOTAL_W-1:0]   i_cfg_data  = '0;

    t_lca_scoreboard sb;
    int unsigned   items_sent   = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   stall_left   = 0;
    int unsigned   free_left    = 0;
    bit            wind_down    = 1'b0;
    bit            no_gaps      = 1'b0;

    int unsigned   parent_of [VERTICES];
    int unsigned   depth_of  [VERTICES];
    int unsigned   seq       [VERTICES];

    tree_ancestor_query_engine #(
        .MAX_VERTICES (VERTICES),
        .LIFT_LEVELS  (LEVELS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .i_depth_in  (i_depth_in),
        .i_steps     (i_steps),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ancestor  (o_ancestor),
        .o_distance  (o_distance),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // answer side back-pressure
    always @(negedge i_clk) begin
        if (wind_down || free_left > 0) begin
            i_out_ready <= 1'b1;
            if (free_left > 0) free_left--;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 63) == 0) free_left = $urandom_range(50, 200);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_ancestor, o_distance, o_status);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tree_ancestor_query_engine verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [9:0] rnd10();
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic put_item(logic [OP_W-1:0] op, t_vertex a, t_vertex b,
                            t_depth dep, t_steps k);
        if (!wind_down && !no_gaps && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_vertex_a <= a;
        i_vertex_b <= b;
        i_depth_in <= dep;
        i_steps    <= k;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, a, b, dep, k);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // every vertex below n gets loaded before the build, so no unwritten entry is read
    task automatic grow_tree(int unsigned n, int unsigned top, int unsigned branch_odds);
        int unsigned j;
        int unsigned t;
        int unsigned p;
        int unsigned v;
        for (int unsigned i = 0; i < n; i++) seq[i] = i;
        t = seq[0]; seq[0] = seq[top]; seq[top] = t;
        for (int unsigned i = n - 1; i >= 2 && i < n; i--) begin
            j = $urandom_range(1, i);
            t = seq[i]; seq[i] = seq[j]; seq[j] = t;
        end
        parent_of[top] = top;
        depth_of[top]  = 0;
        for (int unsigned i = 1; i < n; i++) begin
            if ($urandom_range(0, branch_odds - 1) == 0) p = seq[$urandom_range(0, i - 1)];
            else p = seq[i - 1];
            parent_of[seq[i]] = p;
            depth_of[seq[i]]  = depth_of[p] + 1;
        end
        for (int unsigned i = n - 1; i >= 1 && i < n; i--) begin
            j = $urandom_range(0, i);
            t = seq[i]; seq[i] = seq[j]; seq[j] = t;
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (n < VERTICES && $urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    put_item(OP_LOAD, VTX_W'($urandom_range(n, 1023)), rnd10(), rnd10(),
                             rnd10());
                end else begin
                    put_item(OP_LOAD, VTX_W'($urandom_range(0, n - 1)),
                             VTX_W'($urandom_range(n, 1023)), rnd10(), rnd10());
                end
            end
            v = seq[i];
            if (v == top) begin
                put_item(OP_LOAD, VTX_W'(v), VTX_W'($urandom_range(0, n - 1)), rnd10(),
                         rnd10());
            end else begin
                put_item(OP_LOAD, VTX_W'(v), VTX_W'(parent_of[v]), DEP_W'(depth_of[v]),
                         rnd10());
            end
        end
        put_item(OP_BUILD, rnd10(), rnd10(), rnd10(), rnd10());
    endtask

    task automatic ask_queries(int unsigned n, int unsigned count, int unsigned top);
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        int unsigned d;
        for (int unsigned c = 0; c < count; c++) begin
            pick = $urandom_range(0, 99);
            a    = $urandom_range(0, n - 1);
            b    = $urandom_range(0, n - 1);
            if (pick < 45 || (pick < 52 && n >= VERTICES)) begin
                put_item(OP_LCA, VTX_W'(a), VTX_W'(b), rnd10(), rnd10());
            end else if (pick < 52) begin
                if ($urandom_range(0, 1) == 0) a = $urandom_range(n, 1023);
                else b = $urandom_range(n, 1023);
                put_item(OP_LCA, VTX_W'(a), VTX_W'(b), rnd10(), rnd10());
            end else if (pick < 85) begin
                put_item(OP_KTH, VTX_W'(a), rnd10(), rnd10(),
                         STEP_W'($urandom_range(0, depth_of[a])));
            end else if (pick < 92 || (pick < 95 && n >= VERTICES)) begin
                put_item(OP_KTH, VTX_W'(a), rnd10(), rnd10(), rnd10());
            end else if (pick < 95) begin
                put_item(OP_KTH, VTX_W'($urandom_range(n, 1023)), rnd10(), rnd10(), rnd10());
            end else if (pick < 97) begin
                put_item(OP_BUILD, rnd10(), rnd10(), rnd10(), rnd10());
            end else begin
                // stray reload, levels stay stale until the next build
                d = $urandom_range(0, 1023);
                put_item(OP_LOAD, VTX_W'(a), VTX_W'(b), DEP_W'(d), rnd10());
                depth_of[a] = (a == top) ? 0 : d;
            end
        end
    endtask

    initial begin
        int unsigned n;
        int unsigned top;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-vertex tree under the reset settings
        put_item(OP_KTH, 10'd1023, 10'd0, 10'd0, 10'd1023);
        put_item(OP_LCA, 10'd0, 10'd1023, 10'd0, 10'd0);
        put_item(OP_LOAD, 10'd0, 10'd1023, 10'd0, 10'd0);
        put_item(OP_LOAD, 10'd0, 10'd0, 10'd1023, 10'd0);
        put_item(OP_BUILD, 10'd0, 10'd0, 10'd0, 10'd0);
        put_item(OP_LCA, 10'd0, 10'd0, 10'd0, 10'd0);
        put_item(OP_KTH, 10'd0, 10'd0, 10'd0, 10'd1);
        drain();

        // small hand-made tree rooted at 7
        write_reg(CFG_VERTEX_TOTAL, 11'd8);
        write_reg(CFG_ROOT_VERTEX, 11'd7);
        put_item(OP_LOAD, 10'd7, 10'd2, 10'd5, 10'd0);
        put_item(OP_LOAD, 10'd3, 10'd7, 10'd1, 10'd0);
        put_item(OP_LOAD, 10'd5, 10'd7, 10'd1, 10'd0);
        put_item(OP_LOAD, 10'd0, 10'd3, 10'd2, 10'd0);
        put_item(OP_LOAD, 10'd6, 10'd3, 10'd2, 10'd0);
        put_item(OP_LOAD, 10'd1, 10'd0, 10'd3, 10'd0);
        put_item(OP_LOAD, 10'd2, 10'd6, 10'd3, 10'd0);
        put_item(OP_LOAD, 10'd4, 10'd1, 10'd4, 10'd0);
        put_item(OP_LOAD, 10'd1023, 10'd0, 10'd0, 10'd0);
        put_item(OP_BUILD, 10'd0, 10'd0, 10'd0, 10'd0);
        put_item(OP_LCA, 10'd4, 10'd2, 10'd0, 10'd0);
        put_item(OP_LCA, 10'd0, 10'd4, 10'd0, 10'd0);
        put_item(OP_LCA, 10'd4, 10'd4, 10'd0, 10'd0);
        put_item(OP_LCA, 10'd5, 10'd2, 10'd0, 10'd0);
        put_item(OP_KTH, 10'd4, 10'd0, 10'd0, 10'd4);
        put_item(OP_KTH, 10'd4, 10'd0, 10'd0, 10'd5);
        put_item(OP_KTH, 10'd2, 10'd0, 10'd0, 10'd2);
        put_item(OP_LCA, 10'd1, 10'd8, 10'd0, 10'd0);
        // depth that disagrees with the parents, distance wraps
        put_item(OP_LOAD, 10'd3, 10'd7, 10'd1000, 10'd0);
        put_item(OP_LCA, 10'd0, 10'd6, 10'd0, 10'd0);
        drain();

        // empty vertex range
        write_reg(CFG_VERTEX_TOTAL, 11'd0);
        put_item(OP_LOAD, rnd10(), rnd10(), rnd10(), rnd10());
        put_item(OP_BUILD, rnd10(), rnd10(), rnd10(), rnd10());
        put_item(OP_LCA, rnd10(), rnd10(), rnd10(), rnd10());
        put_item(OP_KTH, rnd10(), rnd10(), rnd10(), rnd10());
        drain();

        // full-size deep tree
        write_reg(CFG_VERTEX_TOTAL, 11'd1024);
        write_reg(CFG_ROOT_VERTEX, 11'd1023);
        grow_tree(VERTICES, VERTICES - 1, 64);
        ask_queries(VERTICES, 60, VERTICES - 1);
        drain();
        write_reg(CFG_VERTEX_TOTAL, 11'd2047);
        write_reg(CFG_ROOT_VERTEX, 11'd0);
        ask_queries(VERTICES, 40, 0);

        while (items_sent < 1700) begin
            drain();
            n       = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 40);
            top     = $urandom_range(0, n - 1);
            no_gaps = ($urandom_range(0, 3) == 0);
            write_reg(CFG_VERTEX_TOTAL, TOTAL_W'(n));
            write_reg(CFG_ROOT_VERTEX, TOTAL_W'(top));
            grow_tree(n, top, $urandom_range(1, 6));
            ask_queries(n, $urandom_range(10, 40), top);
        end

        // closing stretch at full rate
        drain();
        wind_down = 1'b1;
        n         = $urandom_range(20, 40);
        top       = $urandom_range(0, n - 1);
        write_reg(CFG_VERTEX_TOTAL, TOTAL_W'(n));
        write_reg(CFG_ROOT_VERTEX, TOTAL_W'(top));
        grow_tree(n, top, $urandom_range(1, 6));
        ask_queries(n, (items_sent < 1750) ? 1900 - items_sent : 150, top);
        drain();
        repeat (200) @(posedge i_clk);

        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("tree_ancestor_query_engine verification clean");
        end else begin
            $display("tree_ancestor_query_engine verification failed");
        end
        $finish;
    end

endmodule
